/* sv/csu_pkg.sv */
package csu_pkg;

    // fixed field and accumulator widths
    localparam int ELEM_W    = 16;
    localparam int DOT_W     = 42;
    localparam int NORM_W    = 41;
    localparam int FRAC_BITS = 15;
    localparam int Q_W       = 16;

    // multiplier split of the norm product into half-width partial products
    localparam int HALF_W    = 21;
    localparam int HI_W      = NORM_W - HALF_W;
    localparam int PP_W      = 2 * HALF_W;
    localparam int MUL_STEPS = 4;

    // radicand holds the norm product, padded to an even bit count
    localparam int ROOT_W     = 42;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;

    // quotient is formed one bit per cycle
    localparam int DREM_W    = ROOT_W + 1;
    localparam int DIV_STEPS = Q_W;

    localparam int CNT_W = $clog2(SQRT_STEPS);

    // stream payload widths
    localparam int S_TDATA_W = 2 * ELEM_W;
    localparam int M_TDATA_W = Q_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_SQRT,
        S_DINIT,
        S_DIV,
        S_DONE
    } t_csu_state;

    // controller to datapath
    typedef struct packed {
        logic       acc_en;
        logic       mul_clr;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_csu_cmd;

    // datapath to controller
    typedef struct packed {
        logic norm_zero;
    } t_csu_sts;

endpackage

/* sv/csu_ctrl.sv */
module csu_ctrl
    import csu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  logic     i_s_tlast,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    input  t_csu_sts i_sts,
    output t_csu_cmd o_cmd
);

    t_csu_state       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_m_valid, n_m_valid;

    // state, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_m_valid = r_m_valid;
        o_cmd     = '0;
        o_s_tready = 1'b0;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.acc_en = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt = '0;
                if (i_sts.norm_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_clr = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                o_cmd.mul_sel  = r_cnt[1:0];
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // load once the output slot is free or being emptied
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;

    // a last item closes the input until its result is loaded
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input still open after last item");

    // a taken result is not offered again unless a new one was loaded
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && i_m_tready && !o_cmd.out_load) |=> !r_m_valid)
        else $error("result repeated");

    // the divider starts only after the full root sequence
    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DINIT) |->
            ($past(r_state) == S_SQRT && $past(r_cnt) == CNT_W'(SQRT_STEPS - 1)))
        else $error("divide started before root finished");

    // a result load never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_m_valid || i_m_tready))
        else $error("result overwritten");

endmodule

/* sv/csu_datapath.sv */
module csu_datapath
    import csu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [ELEM_W-1:0] i_elem_a,
    input  logic signed [ELEM_W-1:0] i_elem_b,
    input  t_csu_cmd                 i_cmd,
    output t_csu_sts                 o_sts,
    output logic        [Q_W-1:0]    o_similarity,
    output logic                     o_zero_norm
);

    logic [DOT_W-1:0]  r_dot;
    logic [NORM_W-1:0] r_norm_a;
    logic [NORM_W-1:0] r_norm_b;
    logic [RAD_W-1:0]  r_prod;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [DREM_W-1:0] r_drem;
    logic              r_nbit;
    logic [Q_W-1:0]    r_q;
    logic              r_neg;
    logic              r_sat;
    logic [Q_W-1:0]    r_sim;
    logic              r_zn;

    logic signed [2*ELEM_W-1:0] w_ab, w_aa, w_bb;
    logic [HALF_W-1:0]  w_op_x, w_op_y;
    logic [PP_W-1:0]    w_pp;
    logic [RAD_W-1:0]   w_pp_ext, w_pp_sh;
    logic [REM_W-1:0]   w_rem_sh, w_trial;
    logic [DOT_W-1:0]   w_mag;
    logic [DREM_W-1:0]  w_drem_sh, w_den;
    logic               w_norm_zero;
    logic [Q_W-1:0]     w_sim;

    // element products for the three sums
    assign w_ab = i_elem_a * i_elem_b;
    assign w_aa = i_elem_a * i_elem_a;
    assign w_bb = i_elem_b * i_elem_b;

    assign w_norm_zero = (r_norm_a == '0) || (r_norm_b == '0);
    assign o_sts.norm_zero = w_norm_zero;

    // accumulators, cleared at reset and when the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot    <= '0;
            r_norm_a <= '0;
            r_norm_b <= '0;
        end else if (i_cmd.out_load) begin
            r_dot    <= '0;
            r_norm_a <= '0;
            r_norm_b <= '0;
        end else if (i_cmd.acc_en) begin
            r_dot    <= r_dot + {{(DOT_W - 2*ELEM_W){w_ab[2*ELEM_W-1]}}, w_ab};
            r_norm_a <= r_norm_a + {{(NORM_W - 2*ELEM_W){1'b0}}, w_aa};
            r_norm_b <= r_norm_b + {{(NORM_W - 2*ELEM_W){1'b0}}, w_bb};
        end
    end

    // norm product by half-width partial products, one per cycle
    assign w_op_x = i_cmd.mul_sel[0] ? {{(HALF_W - HI_W){1'b0}}, r_norm_a[NORM_W-1:HALF_W]}
                                     : r_norm_a[HALF_W-1:0];
    assign w_op_y = i_cmd.mul_sel[1] ? {{(HALF_W - HI_W){1'b0}}, r_norm_b[NORM_W-1:HALF_W]}
                                     : r_norm_b[HALF_W-1:0];
    assign w_pp     = w_op_x * w_op_y;
    assign w_pp_ext = {{(RAD_W - PP_W){1'b0}}, w_pp};

    always_comb begin
        case (i_cmd.mul_sel)
            2'd0:    w_pp_sh = w_pp_ext;
            2'd3:    w_pp_sh = w_pp_ext << (2 * HALF_W);
            default: w_pp_sh = w_pp_ext << HALF_W;
        endcase
    end

    // root step: two radicand bits in, one root bit out
    assign w_rem_sh = {r_rem[REM_W-3:0], r_prod[RAD_W-1:RAD_W-2]};
    assign w_trial  = {{(REM_W - ROOT_W - 2){1'b0}}, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_clr) begin
            r_prod <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.mul_step) begin
            r_prod <= r_prod + w_pp_sh;
        end else if (i_cmd.sqrt_step) begin
            r_prod <= {r_prod[RAD_W-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // magnitude of the dot product and divider setup
    assign w_mag     = r_dot[DOT_W-1] ? (DOT_W'(0) - r_dot) : r_dot;
    assign w_den     = {1'b0, r_root};
    assign w_drem_sh = {r_drem[DREM_W-2:0], r_nbit};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_neg  <= r_dot[DOT_W-1];
            // quotient of 2^16 or more whenever mag >= 2 * root
            r_sat  <= {1'b0, w_mag} >= {r_root, 1'b0};
            r_drem <= {{(DREM_W - DOT_W + 1){1'b0}}, w_mag[DOT_W-1:1]};
            r_nbit <= w_mag[0];
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            r_nbit <= 1'b0;
            if (w_drem_sh >= w_den) begin
                r_drem <= w_drem_sh - w_den;
                r_q    <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_drem <= w_drem_sh;
                r_q    <= {r_q[Q_W-2:0], 1'b0};
            end
        end
    end

    // clamp to the Q1.15 range
    always_comb begin
        if (r_neg) begin
            if (r_sat || (r_q > Q_W'(2**FRAC_BITS))) begin
                w_sim = Q_W'(2**FRAC_BITS);
            end else begin
                w_sim = Q_W'(0) - r_q;
            end
        end else begin
            if (r_sat || (r_q > Q_W'(2**FRAC_BITS - 1))) begin
                w_sim = Q_W'(2**FRAC_BITS - 1);
            end else begin
                w_sim = r_q;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sim <= w_norm_zero ? '0 : w_sim;
            r_zn  <= w_norm_zero;
        end
    end

    assign o_similarity = r_sim;
    assign o_zero_norm  = r_zn;

endmodule

/* sv/cosine_similarity_unit.sv */
// channel   dir  width  contents
// s_axis    in   32     tdata: elem_a [15:0], elem_b [31:16]; tlast: last
// m_axis    out  16     tdata: similarity [15:0]; tuser: zero_norm [0]
//
// one element pair is taken per cycle while the input is open; pairs stream back to back
// a last pair closes the input until its result is loaded: a norm check, 4 partial-product
// steps of the norm product, 42 root steps, 1 setup and 16 quotient steps; only the check with a zero norm
// synchronous active-low reset clears the controller, the sums and the output valid
// a result waiting on m_axis does not hold up input until the next last pair
module cosine_similarity_unit
    import csu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // elem_a [15:0], elem_b [31:16]
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // similarity [15:0]
    output logic [0:0]           o_m_tuser    // zero_norm [0]
);

    t_csu_cmd w_cmd;
    t_csu_sts w_sts;
    logic     w_zero_norm;

    csu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    csu_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_a     (signed'(i_s_tdata[ELEM_W-1:0])),
        .i_elem_b     (signed'(i_s_tdata[2*ELEM_W-1:ELEM_W])),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_similarity (o_m_tdata),
        .o_zero_norm  (w_zero_norm)
    );

    assign o_m_tuser[0] = w_zero_norm;

endmodule

/* verif/similarity_checker.sv */
module similarity_checker
    import csu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // elem_a [15:0], elem_b [31:16]
    input  logic                 i_s_tlast,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // similarity [15:0]
    input  logic [0:0]           i_m_tuser,   // zero_norm [0]
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SIM_POS_MAX = 2 ** (Q_W - 1) - 1;
    localparam longint SIM_NEG_MAG = 2 ** (Q_W - 1);

    typedef struct packed {
        logic signed [Q_W-1:0] similarity;
        logic                  zero_norm;
    } t_similarity;

    // results predicted from closed vectors, oldest first
    t_similarity             similarity_q[$];
    logic signed [DOT_W-1:0] dot_sum;
    logic [NORM_W-1:0]       norm_a_sum;
    logic [NORM_W-1:0]       norm_b_sum;
    int                      fail_total;

    // floor root of the norm product, then truncated and clamped quotient
    function automatic t_similarity cosine_from_sums(logic signed [DOT_W-1:0] dot,
                                                     logic [NORM_W-1:0] norm_a,
                                                     logic [NORM_W-1:0] norm_b);
        logic [RAD_W-1:0]               radicand;
        logic [ROOT_W-1:0]              root;
        logic [ROOT_W-1:0]              trial;
        logic [DOT_W-1:0]               mag;
        logic [DOT_W+FRAC_BITS-1:0]     quot;
        t_similarity                    res;
        res = '0;
        if (norm_a == '0 || norm_b == '0) begin
            res.zero_norm = 1'b1;
        end else begin
            radicand = RAD_W'(norm_a) * RAD_W'(norm_b);
            root = '0;
            for (int i = ROOT_W - 1; i >= 0; i--) begin
                trial = root | (ROOT_W'(1) << i);
                if (RAD_W'(trial) * RAD_W'(trial) <= radicand)
                    root = trial;
            end
            // most negative sum negates onto itself, which is its magnitude unsigned
            mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
            quot = {mag, {FRAC_BITS{1'b0}}} / (DOT_W + FRAC_BITS)'(root);
            if (dot[DOT_W-1]) begin
                if (quot > SIM_NEG_MAG)
                    quot = SIM_NEG_MAG;
                res.similarity = Q_W'(-quot);
            end else begin
                if (quot > SIM_POS_MAX)
                    quot = SIM_POS_MAX;
                res.similarity = quot[Q_W-1:0];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [ELEM_W-1:0]   elem_a;
        logic signed [ELEM_W-1:0]   elem_b;
        logic signed [2*ELEM_W-1:0] prod_ab;
        logic signed [2*ELEM_W-1:0] sq_a;
        logic signed [2*ELEM_W-1:0] sq_b;
        t_similarity                got;
        t_similarity                want;
        if (!i_rst_n) begin
            dot_sum    = '0;
            norm_a_sum = '0;
            norm_b_sum = '0;
            fail_total = 0;
        end else begin
            // fold each accepted pair, close the vector on last
            if (i_s_tvalid && i_s_tready) begin
                elem_a     = i_s_tdata[ELEM_W-1:0];
                elem_b     = i_s_tdata[2*ELEM_W-1:ELEM_W];
                prod_ab    = elem_a * elem_b;
                sq_a       = elem_a * elem_a;
                sq_b       = elem_b * elem_b;
                dot_sum    = dot_sum + prod_ab;
                norm_a_sum = norm_a_sum + NORM_W'($unsigned(sq_a));
                norm_b_sum = norm_b_sum + NORM_W'($unsigned(sq_b));
                if (i_s_tlast) begin
                    similarity_q = {similarity_q,
                                    cosine_from_sums(dot_sum, norm_a_sum, norm_b_sum)};
                    dot_sum    = '0;
                    norm_a_sum = '0;
                    norm_b_sum = '0;
                end
            end
            // compare each delivered result with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got.similarity = i_m_tdata;
                got.zero_norm  = i_m_tuser[0];
                if (similarity_q.size() == 0) begin
                    $display("%0t: unexpected result, similarity %0d zero_norm %0b", $time,
                             $signed(got.similarity), got.zero_norm);
                    fail_total++;
                end else begin
                    want = similarity_q.pop_front();
                    if (got.similarity !== want.similarity) begin
                        $display("%0t: similarity mismatch, expected %0d, got %0d", $time,
                                 $signed(want.similarity), $signed(got.similarity));
                        fail_total++;
                    end
                    if (got.zero_norm !== want.zero_norm) begin
                        $display("%0t: zero_norm mismatch, expected %0b, got %0b", $time,
                                 want.zero_norm, got.zero_norm);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= similarity_q.size();
    end

endmodule

/* verif/tb_cosine_similarity_unit.sv */
module tb_cosine_similarity_unit
    import csu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 500;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;   // elem_a [15:0], elem_b [31:16]
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;        // similarity [15:0]
    logic [0:0]           o_m_tuser;        // zero_norm [0]

    int fail_count;
    int results_pending;
    int tx_idle_pct = 26;
    int rx_idle_pct = 82;
    int rx_hold_left = 0;
    int pairs_sent = 0;

    cosine_similarity_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    similarity_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, or a counted hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                i_m_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one element pair after a random gap, return once accepted
    task automatic send_pair(input logic [ELEM_W-1:0] elem_a, input logic [ELEM_W-1:0] elem_b,
                             input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {elem_b, elem_a};
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pairs_sent++;
    endtask

    // element values weighted toward extremes and small magnitudes
    function automatic logic [ELEM_W-1:0] pick_elem();
        logic [ELEM_W-1:0] val;
        case ($urandom_range(9))
            0, 1: begin
                case ($urandom_range(4))
                    0:       val = 16'h7FFF;
                    1:       val = 16'h8000;
                    2:       val = 16'h0001;
                    3:       val = 16'hFFFF;
                    default: val = 16'h0000;
                endcase
            end
            2, 3: begin
                val = ELEM_W'($urandom_range(8) - 4);
            end
            default: begin
                val = ELEM_W'($urandom);
            end
        endcase
        return val;
    endfunction

    // one vector of random length and shape
    task automatic send_random_vector();
        int                len;
        int                shape;
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
        case ($urandom_range(19))
            0:                        len = $urandom_range(200, 33);
            1, 2, 3, 4, 5:            len = $urandom_range(32, 7);
            default:                  len = $urandom_range(6, 1);
        endcase
        shape = $urandom_range(99);
        for (int i = 0; i < len; i++) begin
            elem_a = pick_elem();
            elem_b = pick_elem();
            // zero vectors, parallel and anti-parallel pairs
            if (shape < 8)
                elem_a = '0;
            else if (shape < 12)
                elem_b = '0;
            else if (shape < 22)
                elem_b = elem_a;
            else if (shape < 27)
                elem_b = -elem_a;
            send_pair(elem_a, elem_b, i == len - 1);
        end
    endtask

    initial begin
        #5_000_000;
        $display("** cosine_similarity_unit: FAILED **");
        $finish;
    end

    initial begin
        int target;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-pair vectors at the extremes, both zero-norm sides
        send_pair(16'h7FFF, 16'h7FFF, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        send_pair(16'h7FFF, 16'h8000, 1'b1);
        send_pair(16'h0000, 16'h0005, 1'b1);
        send_pair(16'hFFF9, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h0001, 16'h0001, 1'b1);
        send_pair(16'hFFFF, 16'h0001, 1'b1);
        // orthogonal pair of vectors
        send_pair(16'h0001, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'h0001, 1'b1);
        // floored root pushes the quotient up to one
        send_pair(16'h0001, 16'h0001, 1'b0);
        send_pair(16'h0001, 16'h0002, 1'b1);
        send_pair(16'h0001, 16'hFFFF, 1'b0);
        send_pair(16'h0002, 16'hFFFD, 1'b1);
        // alternating bit patterns
        send_pair(16'h5555, 16'hAAAA, 1'b0);
        send_pair(16'hAAAA, 16'h5555, 1'b1);

        // idle mix: sender light and receiver heavy, then swapped
        target = pairs_sent + PHASE_ITEMS;
        while (pairs_sent < target)
            send_random_vector();
        tx_idle_pct = 82;
        rx_idle_pct = 26;
        target = pairs_sent + PHASE_ITEMS;
        while (pairs_sent < target)
            send_random_vector();

        // no idling; receiver holds off while vectors keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_left = 400;
        for (int i = 0; i < 12; i++)
            send_random_vector();
        // sender waits for the block to drain completely
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
        target = pairs_sent + PHASE_ITEMS;
        while (pairs_sent < target)
            send_random_vector();
        i_s_tvalid <= 1'b0;

        // drain, then allow the block's latency to pass
        @(posedge i_clk);
        for (int w = 0; w < 200000 && results_pending != 0; w++)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (results_pending != 0)
            $display("%0t: %0d expected results never arrived", $time, results_pending);
        if (fail_count == 0 && results_pending == 0) begin
            $display("** cosine_similarity_unit: PASSED **");
        end else begin
            $display("** cosine_similarity_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* cosine_similarity_unit.f */
sv/csu_pkg.sv
sv/csu_ctrl.sv
sv/csu_datapath.sv
sv/cosine_similarity_unit.sv
verif/similarity_checker.sv
verif/tb_cosine_similarity_unit.sv
